[rtl/rhlc_pkg.sv]
package rhlc_pkg;

	// Character codes
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_VT = 8'h0B;
	localparam logic [7:0] CHAR_FF = 8'h0C;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// Method table, names padded with spaces to the longest name
	localparam int NUM_METHODS = 11;
	localparam int METHOD_CHARS = 13;
	localparam logic [8*METHOD_CHARS-1:0] METHOD_NAMES [NUM_METHODS] = '{
		"DESCRIBE     ", "ANNOUNCE     ", {"GET_", "PARAMETER"}, "OPTIONS      ",
		"PAUSE        ", "PLAY         ", "RECORD       ", "REDIRECT     ",
		"SETUP        ", {"SET_", "PARAMETER"}, "TEARDOWN     "
	};
	localparam logic [3:0] METHOD_LENS [NUM_METHODS] = '{
		4'd8, 4'd8, 4'd13, 4'd7, 4'd5, 4'd4, 4'd6, 4'd8, 4'd5, 4'd13, 4'd8
	};

	localparam int REPLY_LEN = 5;
	localparam logic [8*REPLY_LEN-1:0] REPLY_TAG = "RTSP/";

	// Content-type header name followed by the value being matched
	localparam int CTYPE_HDR_LEN = 13;
	localparam int CTYPE_FULL_LEN = 28;
	localparam logic [8*CTYPE_FULL_LEN-1:0] CTYPE_STR = "CONTENT-TYPE:APPLICATION/SDP";
	localparam logic [4:0] CM_HDR = 5'd13;
	localparam logic [4:0] CM_FULL = 5'd28;
	localparam logic [4:0] CM_OK = 5'd29;
	localparam logic [4:0] CM_FAIL = 5'd30;

	localparam logic [4:0] LINE_POS_MAX = 5'd31;

	typedef enum logic [2:0] {
		CLS_REQUEST = 3'd0,
		CLS_REPLY = 3'd1,
		CLS_BLANK = 3'd2,
		CLS_HEADER = 3'd3,
		CLS_NOT_RTSP = 3'd4
	} line_class_t;

	typedef enum logic [1:0] {
		SCAN_UNDECIDED = 2'd0,
		SCAN_HEADER = 2'd1,
		SCAN_NOT = 2'd2
	} scan_phase_t;

	typedef enum logic [1:0] {
		STAT_TOKEN = 2'd0,
		STAT_GAP = 2'd1,
		STAT_DIGITS = 2'd2,
		STAT_DONE = 2'd3
	} status_phase_t;

	typedef struct packed {
		logic [4:0] line_pos;
		logic [NUM_METHODS-1:0] method_alive;
		logic reply_alive;
		scan_phase_t scan_phase;
		logic [4:0] cm_phase;
		status_phase_t status_phase;
		logic [15:0] status_value;
		logic sdp_flag;
		logic in_body;
		logic after_cr;
	} parse_state_t;

	localparam parse_state_t PARSE_STATE_RESET = '{
		line_pos: 5'd0,
		method_alive: '1,
		reply_alive: 1'b1,
		scan_phase: SCAN_UNDECIDED,
		cm_phase: 5'd0,
		status_phase: STAT_TOKEN,
		status_value: 16'd0,
		sdp_flag: 1'b0,
		in_body: 1'b0,
		after_cr: 1'b0
	};

	typedef struct packed {
		logic line_done;
		line_class_t line_class;
		logic [3:0] method_index;
		logic [15:0] status_code;
		logic sdp_seen;
		logic body_byte;
	} line_result_t;

	function automatic logic [7:0] fold_upper(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	endfunction

	function automatic logic inline_space(logic [7:0] c);
		return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF;
	endfunction

	function automatic logic is_tspecial(logic [7:0] c);
		logic r;
		unique case (c)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h5C,
			8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Character p of method m (p below the method length)
	function automatic logic [7:0] method_char(logic [3:0] m, logic [3:0] p);
		return METHOD_NAMES[m][8*(METHOD_CHARS-1-int'(p)) +: 8];
	endfunction

	function automatic logic [7:0] reply_char(logic [2:0] p);
		return REPLY_TAG[8*(REPLY_LEN-1-int'(p)) +: 8];
	endfunction

	function automatic logic [7:0] ctype_char(logic [4:0] p);
		return CTYPE_STR[8*(CTYPE_FULL_LEN-1-int'(p)) +: 8];
	endfunction

endpackage

[rtl/rhlc_in_if.sv]
interface rhlc_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

[rtl/rhlc_out_if.sv]
interface rhlc_out_if;
	logic valid;
	logic ready;
	logic line_done;
	logic [2:0] line_class;
	logic [3:0] method_index;
	logic [15:0] status_code;
	logic sdp_seen;
	logic body_byte;

	modport source(output valid, line_done, line_class, method_index, status_code,
		sdp_seen, body_byte, input ready);
	modport sink(input valid, line_done, line_class, method_index, status_code,
		sdp_seen, body_byte, output ready);
endinterface

[rtl/rtsp_header_line_classifier_top.sv]
// RTSP header line classifier. Takes one message byte per cycle unless the result
// side stalls, and returns one result per byte, in order; a byte is held in the
// input register, then its result in the result register. The parse state (method
// prefix masks, reply tag match, header scan, content-type match and the status
// multiply-add) is updated as each byte moves from the input to the result register.
// Each result is held in an output register, so a stalled consumer does not stop
// the next byte from being taken in until both stages are full.
module rtsp_header_line_classifier_top (
	input logic clk,
	input logic arst_n,
	rhlc_in_if.sink msg,
	rhlc_out_if.source res
);
	import rhlc_pkg::*;

	logic s1_valid_q;
	logic [7:0] data_byte_s1;
	logic last_byte_s1;
	parse_state_t st_q;
	parse_state_t st_next;
	line_result_t step_result;
	logic out_valid_q;
	line_result_t out_q;
	logic adv;

	// Stage 1 moves into the result register when that register frees up
	assign adv = s1_valid_q && (!out_valid_q || res.ready);
	assign msg.ready = !s1_valid_q || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (msg.ready) begin
			s1_valid_q <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			data_byte_s1 <= msg.data_byte;
			last_byte_s1 <= msg.last_byte;
		end
	end

	rhlc_step u_step (
		.st(st_q),
		.data_byte(data_byte_s1),
		.last_byte(last_byte_s1),
		.st_next(st_next),
		.result(step_result)
	);

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PARSE_STATE_RESET;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= step_result;
	end

	assign res.valid = out_valid_q;
	assign res.line_done = out_q.line_done;
	assign res.line_class = out_q.line_class;
	assign res.method_index = out_q.method_index;
	assign res.status_code = out_q.status_code;
	assign res.sdp_seen = out_q.sdp_seen;
	assign res.body_byte = out_q.body_byte;

	// A byte that ends no line carries no class or status
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.line_done) |->
			(out_q.line_class == CLS_REQUEST && out_q.status_code == 16'd0
				&& out_q.method_index == 4'd0))
		else $error("classification fields set without a finished line");

	// A finished line flagged as body must be the one that ended the header section
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.line_done && out_q.body_byte) |->
			(out_q.line_class == CLS_NOT_RTSP))
		else $error("body flag on a classified header line");

	// Status only comes with a reply line
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status_code != 16'd0) |-> (out_q.line_class == CLS_REPLY))
		else $error("status code on a non-reply line");

	// The final byte of a message returns the parser to its reset state
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_byte_s1) |=> (st_q == PARSE_STATE_RESET))
		else $error("state not cleared after last byte");

	// Body mode only ends with the message
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && st_q.in_body && !last_byte_s1) |=> st_q.in_body)
		else $error("body mode left before end of message");

endmodule

[rtl/rhlc_step.sv]
// Next-state and result logic for one message byte
module rhlc_step (
	input rhlc_pkg::parse_state_t st,
	input logic [7:0] data_byte,
	input logic last_byte,
	output rhlc_pkg::parse_state_t st_next,
	output rhlc_pkg::line_result_t result
);
	import rhlc_pkg::*;

	logic [7:0] fb;
	logic term;
	parse_state_t fd;
	logic [19:0] status_sum;
	logic found;
	logic [3:0] midx;

	assign fb = fold_upper(data_byte);
	assign term = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
	assign status_sum = 20'({st.status_value, 3'b000}) + 20'({st.status_value, 1'b0})
		+ 20'(data_byte - CHAR_ZERO);

	// Line state after taking this byte into the line
	always_comb begin
		fd = st;
		for (int i = 0; i < NUM_METHODS; i++) begin
			if (st.line_pos < {1'b0, METHOD_LENS[i]}
					&& fb != method_char(4'(i), st.line_pos[3:0]))
				fd.method_alive[i] = 1'b0;
		end
		if (st.line_pos < 5'(REPLY_LEN) && fb != reply_char(st.line_pos[2:0]))
			fd.reply_alive = 1'b0;

		if (st.scan_phase == SCAN_UNDECIDED) begin
			if (data_byte < 8'h20 || data_byte > 8'h7E || is_tspecial(data_byte))
				fd.scan_phase = SCAN_NOT;
			else if (data_byte == CHAR_COLON)
				fd.scan_phase = SCAN_HEADER;
		end

		// Content-type match progress
		if (st.cm_phase < CM_HDR) begin
			fd.cm_phase = (fb == ctype_char(st.cm_phase)) ? st.cm_phase + 5'd1 : CM_FAIL;
		end else if (st.cm_phase == CM_HDR) begin
			if (data_byte != CHAR_SPACE && data_byte != CHAR_TAB)
				fd.cm_phase = (fb == ctype_char(CM_HDR)) ? CM_HDR + 5'd1 : CM_FAIL;
		end else if (st.cm_phase < CM_FULL) begin
			fd.cm_phase = (fb == ctype_char(st.cm_phase)) ? st.cm_phase + 5'd1 : CM_FAIL;
		end else if (st.cm_phase == CM_FULL) begin
			fd.cm_phase = inline_space(data_byte) ? CM_OK : CM_FAIL;
		end

		// Reply status digits
		unique case (st.status_phase)
			STAT_TOKEN: begin
				if (inline_space(data_byte))
					fd.status_phase = STAT_GAP;
			end
			STAT_GAP, STAT_DIGITS: begin
				if (data_byte >= CHAR_ZERO && data_byte <= CHAR_NINE) begin
					fd.status_value = (|status_sum[19:16]) ? 16'hFFFF : status_sum[15:0];
					fd.status_phase = STAT_DIGITS;
				end else if (!(st.status_phase == STAT_GAP && inline_space(data_byte))) begin
					fd.status_phase = STAT_DONE;
				end
			end
			default: ;
		endcase

		fd.line_pos = (st.line_pos < LINE_POS_MAX) ? st.line_pos + 5'd1 : LINE_POS_MAX;
		if (term)
			fd = st;
	end

	// First live method whose name is complete
	always_comb begin
		found = 1'b0;
		midx = 4'd0;
		for (int i = 0; i < NUM_METHODS; i++) begin
			if (!found && fd.method_alive[i] && fd.line_pos >= {1'b0, METHOD_LENS[i]}) begin
				found = 1'b1;
				midx = 4'(i);
			end
		end
	end

	// Line end handling and classification
	always_comb begin
		st_next = st;
		result = '0;
		result.line_class = CLS_REQUEST;
		if (st.in_body) begin
			result.body_byte = 1'b1;
		end else if (st.after_cr && data_byte == CHAR_LF) begin
			st_next.after_cr = 1'b0;
		end else if (term || last_byte) begin
			result.line_done = 1'b1;
			st_next = PARSE_STATE_RESET;
			st_next.sdp_flag = st.sdp_flag;
			st_next.in_body = st.in_body;
			st_next.after_cr = (data_byte == CHAR_CR);
			priority if (fd.reply_alive && fd.line_pos >= 5'(REPLY_LEN)) begin
				result.line_class = CLS_REPLY;
				result.status_code = fd.status_value;
			end else if (found) begin
				result.line_class = CLS_REQUEST;
				result.method_index = midx;
			end else if (fd.line_pos == 5'd0) begin
				result.line_class = CLS_BLANK;
			end else if (fd.scan_phase == SCAN_HEADER) begin
				result.line_class = CLS_HEADER;
				if (fd.cm_phase == CM_FULL || fd.cm_phase == CM_OK)
					st_next.sdp_flag = 1'b1;
			end else begin
				result.line_class = CLS_NOT_RTSP;
				st_next.in_body = 1'b1;
				result.body_byte = 1'b1;
			end
		end else begin
			st_next = fd;
			st_next.after_cr = 1'b0;
		end
		result.sdp_seen = st_next.sdp_flag;
		if (last_byte)
			st_next = PARSE_STATE_RESET;
	end

endmodule
